// ----- hdl/word_dictionary_encoder_macros.svh -----
// Assertion macros for the word dictionary encoder.
`ifndef WORD_DICTIONARY_ENCODER_MACROS_SVH
`define WORD_DICTIONARY_ENCODER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define WDE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WDE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/wde_pkg.sv -----
// Types for the word dictionary encoder.
package wde_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_REQ,
    ST_CMP,
    ST_APPEND,
    ST_OUT
  } state_t;
endpackage

// ----- hdl/wde_word_buf.sv -----
// Buffer of the word being collected, one synchronous RAM with a compare read port.
module wde_word_buf #(
  parameter int WORD_BYTES = 32,
  localparam int PW = $clog2(WORD_BYTES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic [PW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  logic [7:0] mem [WORD_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- hdl/wde_dict_mem.sv -----
// Dictionary byte store plus per-entry length store, both synchronous RAMs.
module wde_dict_mem #(
  parameter int DICT_DEPTH = 256,
  parameter int WORD_BYTES = 32,
  localparam int PW = $clog2(WORD_BYTES),
  localparam int IW = $clog2(DICT_DEPTH),
  localparam int LW = $clog2(WORD_BYTES + 1)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IW+PW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IW+PW-1:0] rd_addr,
  output logic [7:0]       rd_data,
  input  logic             len_wr_en,
  input  logic [IW-1:0]    len_wr_addr,
  input  logic [LW-1:0]    len_wr_data,
  input  logic [IW-1:0]    len_rd_addr,
  output logic [LW-1:0]    len_rd_data
);
  logic [7:0]    mem [DICT_DEPTH*WORD_BYTES];
  logic [LW-1:0] len_mem [DICT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    if (len_wr_en) begin
      len_mem[len_wr_addr] <= len_wr_data;
    end
    len_rd_data <= len_mem[len_rd_addr];
  end
endmodule

// ----- hdl/word_dictionary_encoder.sv -----
// Word dictionary encoder: collects words byte by byte and codes them by dictionary index.
//
// Input channel in_*: one text byte per item, in_tlast marks the last byte of the text.
// Bytes that do not end a word are taken while the block stays idle. An item that ends a
// word (delimiter byte, or end of text) starts a search of the dictionary: each
// stored entry first has its length checked against the word, and only an entry of
// equal length then has its bytes compared with the word one by one. A new word is,
// after the end-of-list check and if the dictionary has room, copied byte by byte
// into a new entry. The byte-serial walk through the dictionary RAM sets how long
// a word end takes.
// Result channel out_*: one item per finished word, held in an output register;
// the block takes no new byte until that result is taken, so a stalled receiver
// simply holds the block. out_tlast marks the final word of the text.
// Reset (synchronous, rst_n low) empties the word and the dictionary and sets the
// delimiter to a space; no clearing pass is needed since only entries below the
// fill count are read. The dictionary also empties after each final word.
// cfg_we writes cfg_wdata to the delimiter register.
`include "word_dictionary_encoder_macros.svh"
module word_dictionary_encoder #(
  parameter int DICT_DEPTH = 256,
  parameter int WORD_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] word_index
  output logic [2:0] out_tuser,  // [0] is_new, [1] dict_full, [2] truncated
  output logic       out_tlast   // last
);
  localparam int PW = $clog2(WORD_BYTES);
  localparam int IW = $clog2(DICT_DEPTH);
  localparam int LW = $clog2(WORD_BYTES + 1);
  localparam int CW = $clog2(DICT_DEPTH + 1);

  wde_pkg::state_t state_r, state_nxt;
  logic [7:0]    delim_r;
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ent_r, ent_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic          last_r, last_nxt;
  logic          lenchk_r, lenchk_nxt;
  logic [7:0]    oidx_r, oidx_nxt;
  logic [2:0]    ouser_r, ouser_nxt;
  logic          olast_r, olast_nxt;

  logic          in_fire, is_delim, push;
  logic [PW-1:0] wb_wa, wb_ra;
  logic [7:0]    wb_rd, dm_rd;
  logic [IW+PW-1:0] dm_wa, dm_ra;
  logic          dm_we, len_we;
  logic [LW-1:0] len_rd;

  assign in_fire  = in_tvalid && in_tready;
  assign is_delim = (in_tdata == delim_r);
  assign push     = in_fire && !is_delim && (wlen_r != LW'(WORD_BYTES));

  // word buffer: write on push, read at pos during compare/append
  assign wb_wa = wlen_r[PW-1:0];
  assign wb_ra = pos_nxt[PW-1:0];

  wde_word_buf #(.WORD_BYTES(WORD_BYTES)) u_wbuf (
    .clk(clk), .wr_en(push), .wr_addr(wb_wa), .wr_data(in_tdata),
    .rd_addr(wb_ra), .rd_data(wb_rd)
  );

  assign dm_ra  = {ent_nxt[IW-1:0], pos_nxt[PW-1:0]};
  // append copies word byte pos_r (addressed last cycle) into the new entry
  assign dm_we  = (state_r == wde_pkg::ST_APPEND) && (pos_r != wlen_r);
  assign dm_wa  = {count_r[IW-1:0], pos_r[PW-1:0]};
  assign len_we = (state_r == wde_pkg::ST_APPEND) && (pos_r == wlen_r);

  wde_dict_mem #(.DICT_DEPTH(DICT_DEPTH), .WORD_BYTES(WORD_BYTES)) u_dict (
    .clk(clk), .wr_en(dm_we), .wr_addr(dm_wa), .wr_data(wb_rd),
    .rd_addr(dm_ra), .rd_data(dm_rd),
    .len_wr_en(len_we), .len_wr_addr(count_r[IW-1:0]), .len_wr_data(wlen_r),
    .len_rd_addr(ent_nxt[IW-1:0]), .len_rd_data(len_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wde_pkg::ST_IDLE: begin
        if (in_fire && (is_delim || in_tlast)) begin
          state_nxt = wde_pkg::ST_CMP_REQ;
        end
      end
      wde_pkg::ST_CMP_REQ: begin
        state_nxt = wde_pkg::ST_CMP;
      end
      wde_pkg::ST_CMP: begin
        if (lenchk_r) begin
          if (ent_r == count_r) begin
            state_nxt = (count_r == CW'(DICT_DEPTH)) ? wde_pkg::ST_OUT
                                                     : wde_pkg::ST_APPEND;
          end else if (len_rd == wlen_r && wlen_r == '0) begin
            state_nxt = wde_pkg::ST_OUT;
          end
        end else if (dm_rd == wb_rd && pos_r == wlen_r - LW'(1)) begin
          state_nxt = wde_pkg::ST_OUT;
        end
      end
      wde_pkg::ST_APPEND: begin
        if (pos_r == wlen_r) begin
          state_nxt = wde_pkg::ST_OUT;
        end
      end
      wde_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = wde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wde_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wlen_nxt   = wlen_r;
    ovf_nxt    = ovf_r;
    count_nxt  = count_r;
    ent_nxt    = ent_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    lenchk_nxt = lenchk_r;
    oidx_nxt   = oidx_r;
    ouser_nxt  = ouser_r;
    olast_nxt  = olast_r;
    unique case (state_r)
      wde_pkg::ST_IDLE: begin
        ent_nxt = '0;
        pos_nxt = '0;
        if (in_fire) begin
          if (!is_delim) begin
            if (wlen_r == LW'(WORD_BYTES)) begin
              ovf_nxt = 1'b1;
            end else begin
              wlen_nxt = wlen_r + LW'(1);
            end
          end
          last_nxt = in_tlast;
        end
      end
      wde_pkg::ST_CMP_REQ: begin
        lenchk_nxt = 1'b1;
      end
      wde_pkg::ST_CMP: begin
        if (lenchk_r) begin
          if (ent_r == count_r) begin
            pos_nxt = '0;
            if (count_r == CW'(DICT_DEPTH)) begin
              oidx_nxt  = '0;
              ouser_nxt = {ovf_r, 1'b1, 1'b0};
            end else begin
              oidx_nxt  = 8'(count_r);
              ouser_nxt = {ovf_r, 1'b0, 1'b1};
            end
          end else if (len_rd == wlen_r) begin
            oidx_nxt  = 8'(ent_r);
            ouser_nxt = {ovf_r, 1'b0, 1'b0};
            if (wlen_r != '0) begin
              lenchk_nxt = 1'b0;
              pos_nxt    = '0;
            end
          end else begin
            ent_nxt = ent_r + CW'(1);
          end
        end else if (dm_rd != wb_rd) begin
          lenchk_nxt = 1'b1;
          ent_nxt    = ent_r + CW'(1);
          pos_nxt    = '0;
        end else if (pos_r != wlen_r - LW'(1)) begin
          pos_nxt = pos_r + LW'(1);
        end
      end
      wde_pkg::ST_APPEND: begin
        if (pos_r == wlen_r) begin
          count_nxt = count_r + CW'(1);
        end else begin
          pos_nxt = pos_r + LW'(1);
        end
      end
      wde_pkg::ST_OUT: begin
        olast_nxt = last_r;
        if (out_tready) begin
          wlen_nxt = '0;
          ovf_nxt  = 1'b0;
          if (last_r) begin
            count_nxt = '0;
          end
        end
      end
      default: ;
    endcase
    if (state_r != wde_pkg::ST_OUT) begin
      olast_nxt = last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wde_pkg::ST_IDLE;
      delim_r  <= 8'd32;
      wlen_r   <= '0;
      ovf_r    <= 1'b0;
      count_r  <= '0;
      last_r   <= 1'b0;
      lenchk_r <= 1'b0;
      ent_r    <= '0;
      pos_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      if (cfg_we) begin
        delim_r <= cfg_wdata;
      end
      wlen_r   <= wlen_nxt;
      ovf_r    <= ovf_nxt;
      count_r  <= count_nxt;
      last_r   <= last_nxt;
      lenchk_r <= lenchk_nxt;
      ent_r    <= ent_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oidx_r  <= oidx_nxt;
    ouser_r <= ouser_nxt;
    olast_r <= olast_nxt;
  end

  assign in_tready  = (state_r == wde_pkg::ST_IDLE);
  assign out_tvalid = (state_r == wde_pkg::ST_OUT);
  assign out_tdata  = oidx_r;
  assign out_tuser  = ouser_r;
  assign out_tlast  = olast_r;

  `WDE_ASSERT_IMP(a_no_both, out_tvalid, !in_tready)
  `WDE_ASSERT_IMP(a_count_le, 1'b1, count_r <= CW'(DICT_DEPTH))
  `WDE_ASSERT_NXT(a_last_clears, out_tvalid && out_tready && out_tlast, count_r == '0)
  `WDE_ASSERT_IMP(a_flags_excl, out_tvalid, !(out_tuser[0] && out_tuser[1]))
endmodule
